[design/sha_pkg.sv]
// package for the sparse histogram accumulator: sizes, request and error codes
// used by the bin cell, the normaliser and the top level
`default_nettype none
package sha_pkg;
   localparam int SampleValues = 256;
   localparam int MaxBins      = 64;
   localparam int WeightBits   = 24;
   localparam int SlotBits     = 7;
   localparam int SampleBits   = 8;
   localparam int CountBits    = 16;
   localparam int TotalBits    = 32;

   localparam logic [SlotBits-1:0] NO_SLOT = 7'd127;

   localparam logic [2:0] REQ_ADD      = 3'd0;
   localparam logic [2:0] REQ_REMOVE   = 3'd1;
   localparam logic [2:0] REQ_EMIT_RAW = 3'd2;
   localparam logic [2:0] REQ_EMIT_NRM = 3'd3;
   localparam logic [2:0] REQ_CLEAR    = 3'd4;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_ABSENT = 2'd1;
   localparam logic [1:0] ERR_FULL   = 2'd2;

   // command broadcast to every cell of the bin chain
   typedef struct packed {
      logic                  hit_add;   // add count to the cell at idx
      logic                  hit_sub;   // subtract count from the cell at idx
      logic                  append;    // write new bin at idx
      logic                  shift;     // cells at or above idx take neighbor
      logic                  rotate;    // emit rotation: each cell takes next
      logic [SlotBits-1:0]   idx;
      logic [SampleBits-1:0] value;
      logic [CountBits-1:0]  count;
   } sha_cmd_type;
endpackage
`default_nettype wire

[design/sha_cell.sv]
// one bin slot of the chain: holds value and weight, takes its upper
// neighbor on a compaction shift or emit rotation; uses sha_pkg
`default_nettype none
module sha_cell
   import sha_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [SlotBits-1:0]   my_idx,
   input  wire sha_cmd_type           cmd,
   input  wire logic [SampleBits-1:0] nb_value,
   input  wire logic [WeightBits-1:0] nb_weight,
   output logic      [SampleBits-1:0] value_ff,
   output logic      [WeightBits-1:0] weight_ff
);
   logic [SampleBits-1:0] value_in;
   logic [WeightBits-1:0] weight_in;
   logic [WeightBits:0]   sum;

   always_comb begin
      sum       = {1'b0, weight_ff} + {{(WeightBits+1-CountBits){1'b0}}, cmd.count};
      value_in  = value_ff;
      weight_in = weight_ff;
      if (cmd.rotate || (cmd.shift && my_idx >= cmd.idx)) begin
         value_in  = nb_value;
         weight_in = nb_weight;
      end else if (my_idx == cmd.idx) begin
         if (cmd.append) begin
            value_in  = cmd.value;
            weight_in = {{(WeightBits-CountBits){1'b0}}, cmd.count};
         end else if (cmd.hit_add) begin
            // saturate at full scale
            weight_in = sum[WeightBits] ? {WeightBits{1'b1}} : sum[WeightBits-1:0];
         end else if (cmd.hit_sub) begin
            weight_in = weight_ff - {{(WeightBits-CountBits){1'b0}}, cmd.count};
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      weight_ff <= weight_in;
   end
endmodule
`default_nettype wire

[design/sha_norm.sv]
// restoring divider for the normalised emit: (w*65536 + t/2) / t,
// one quotient bit per cycle; uses sha_pkg
`default_nettype none
module sha_norm
   import sha_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [WeightBits-1:0] w,
   input  wire logic [TotalBits-1:0]  total,
   output logic                       busy,
   output logic [WeightBits-1:0]      quot
);
   localparam int NumBits = WeightBits + 16;
   localparam int StepBits = 6;

   logic [NumBits-1:0]   num_ff, num_in;
   logic [TotalBits:0]   rem_ff, rem_in;
   logic [TotalBits-1:0] den_ff, den_in;
   logic [StepBits-1:0]  step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic [TotalBits:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[TotalBits-1:0], num_ff[NumBits-1]};
      if (start) begin
         // the shifted dividend plus half the divisor fits in NumBits+1 bits
         num_in  = {w, 16'd0} + NumBits'(total >> 1);
         rem_in  = {{TotalBits{1'b0}}, ({w, 16'd0} + {1'b0, NumBits'(total >> 1)}) > 
                    {1'b0, {NumBits{1'b1}}}};
         den_in  = total;
         step_in = StepBits'(NumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NumBits-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepBits'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = num_ff[WeightBits-1:0];
endmodule
`default_nettype wire

[design/sparse_histogram_accumulator_core.sv]
// top level of the sparse histogram accumulator: sequencer, slot dictionary
// memory, chain of sha_cell bins and the sha_norm divider; uses sha_pkg
//
// Bins sit in a chain of cells in insertion order; a 256-entry dictionary
// memory maps sample value to slot. After reset, and after a clear, a
// clearing pass walks the dictionary while req_ready stays low. When a
// remove erases its bin, each later bin moves down and rewrites its
// dictionary entry through the single memory port. Emit rotates the chain
// once per beat and then on to a full turn of 64 cells, so the bins end back
// in insertion order; a normalised emit runs the divider on each bin before
// its beat. Stalls on the result side hold an emit, and a held result beat
// keeps req_ready low. Total weight is kept by adding and subtracting
// the change, saturating at 2^32-1.
`default_nettype none
module sparse_histogram_accumulator_core
   import sha_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_type,
   input  wire logic [SampleBits-1:0] req_sample,
   input  wire logic [CountBits-1:0]  req_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [SampleBits-1:0]      rsp_item,
   output logic [WeightBits-1:0]      rsp_weight,
   output logic                       rsp_empty_res,
   output logic [1:0]                 rsp_error_code,
   output logic                       rsp_last
);
   localparam logic [3:0] ST_WIPE   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LOOK   = 4'd2;
   localparam logic [3:0] ST_DECIDE = 4'd3;
   localparam logic [3:0] ST_FIX    = 4'd4;
   localparam logic [3:0] ST_FIXW   = 4'd5;
   localparam logic [3:0] ST_EMIT   = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;
   localparam logic [3:0] ST_TOT    = 4'd9;

   logic [3:0]            state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [SampleBits-1:0] smp_ff, smp_in;
   logic [CountBits-1:0]  cnt_ff, cnt_in;
   logic [SlotBits-1:0]   used_ff, used_in;
   logic [SlotBits-1:0]   slot_ff, slot_in;
   logic [SlotBits-1:0]   ptr_ff, ptr_in;
   logic [TotalBits-1:0]  total_ff, total_in;
   logic [WeightBits-1:0] delta_ff, delta_in;
   logic                  dsub_ff, dsub_in;
   logic [SampleBits-1:0] wipe_ff, wipe_in;

   logic                  rv_ff, rv_in;
   logic [SampleBits-1:0] ritem_ff, ritem_in;
   logic [WeightBits-1:0] rw_ff, rw_in;
   logic                  rempty_ff, rempty_in;
   logic [1:0]            rerr_ff, rerr_in;
   logic                  rlast_ff, rlast_in;

   // dictionary memory, one port
   logic [SlotBits-1:0]   dict [SampleValues];
   logic                  d_we;
   logic [SampleBits-1:0] d_addr;
   logic [SlotBits-1:0]   d_wdata, d_rdata;

   always_ff @(posedge clock) begin
      if (d_we) dict[d_addr] <= d_wdata;
      d_rdata <= dict[d_addr];
   end

   // chain of bins
   sha_cmd_type           cmd;
   logic [SampleBits-1:0] cv [MaxBins];
   logic [WeightBits-1:0] cw [MaxBins];

   for (genvar g = 0; g < MaxBins; g++) begin : g_cell
      localparam int Nb = (g + 1) % MaxBins;
      sha_cell u_cell (
         .clock     (clock),
         .my_idx    (SlotBits'(g)),
         .cmd       (cmd),
         .nb_value  (cv[Nb]),
         .nb_weight (cw[Nb]),
         .value_ff  (cv[g]),
         .weight_ff (cw[g])
      );
   end

   // divider
   logic                  dv_start, dv_busy;
   logic [WeightBits-1:0] dv_quot;

   sha_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .w     (cw[0]),
      .total (total_ff),
      .busy  (dv_busy),
      .quot  (dv_quot)
   );

   logic                  req_beat, rsp_beat, slot_ok, ovf;
   logic [WeightBits-1:0] hw, addw;
   logic [WeightBits:0]   hsum;
   logic [TotalBits:0]    tsum;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rv_ff && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign slot_ok  = (d_rdata < used_ff);
   assign hw       = cw[d_rdata[5:0]];

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      smp_in   = smp_ff;
      cnt_in   = cnt_ff;
      used_in  = used_ff;
      slot_in  = slot_ff;
      ptr_in   = ptr_ff;
      total_in = total_ff;
      delta_in = delta_ff;
      dsub_in  = dsub_ff;
      wipe_in  = wipe_ff;
      rv_in    = rv_ff && !rsp_ready;
      ritem_in = ritem_ff;
      rw_in    = rw_ff;
      rempty_in = rempty_ff;
      rerr_in  = rerr_ff;
      rlast_in = rlast_ff;
      d_we     = 1'b0;
      d_addr   = smp_ff;
      d_wdata  = NO_SLOT;
      dv_start = 1'b0;
      cmd      = '0;
      cmd.idx  = slot_ff;
      cmd.value = smp_ff;
      cmd.count = cnt_ff;
      hsum     = {1'b0, hw} + {{(WeightBits+1-CountBits){1'b0}}, cnt_ff};
      addw     = hsum[WeightBits] ? {WeightBits{1'b1}} : hsum[WeightBits-1:0];
      tsum     = '0;
      ovf      = 1'b0;

      unique case (state_ff)
         ST_WIPE: begin
            d_we    = 1'b1;
            d_addr  = wipe_ff;
            wipe_in = wipe_ff + 1'b1;
            if (wipe_ff == {SampleBits{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            d_addr = req_sample;
            if (req_beat) begin
               op_in  = req_type;
               smp_in = req_sample;
               cnt_in = req_count;
               ptr_in = '0;
               case (req_type)
                  REQ_ADD, REQ_REMOVE: state_in = ST_LOOK;
                  REQ_EMIT_RAW, REQ_EMIT_NRM: begin
                     if (used_ff == '0) begin
                        rv_in = 1'b1; ritem_in = '0; rw_in = '0;
                        rempty_in = 1'b1; rerr_in = ERR_NONE; rlast_in = 1'b1;
                     end else begin
                        state_in = (req_type == REQ_EMIT_NRM) ? ST_DIV : ST_EMIT;
                        dv_start = (req_type == REQ_EMIT_NRM);
                     end
                  end
                  REQ_CLEAR: begin
                     used_in  = '0;
                     total_in = '0;
                     wipe_in  = '0;
                     state_in = ST_WIPE;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOK: begin
            // dictionary data valid now
            slot_in  = d_rdata;
            state_in = ST_TOT;
            dsub_in  = 1'b0;
            if (op_ff == REQ_ADD) begin
               if (slot_ok) begin
                  cmd.idx = d_rdata; cmd.hit_add = 1'b1;
                  delta_in = addw - hw;
               end else if (used_ff == SlotBits'(MaxBins)) begin
                  rv_in = 1'b1; ritem_in = smp_ff; rw_in = '0;
                  rempty_in = 1'b0; rerr_in = ERR_FULL; rlast_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx = used_ff; cmd.append = 1'b1;
                  d_we = 1'b1; d_wdata = used_ff;
                  used_in = used_ff + 1'b1;
                  delta_in = {{(WeightBits-CountBits){1'b0}}, cnt_ff};
               end
            end else if (!slot_ok) begin
               rv_in = 1'b1; ritem_in = smp_ff; rw_in = '0;
               rempty_in = 1'b0; rerr_in = ERR_ABSENT; rlast_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               dsub_in = 1'b1;
               if (hw <= {{(WeightBits-CountBits){1'b0}}, cnt_ff}) begin
                  delta_in = hw;
                  cmd.idx = d_rdata; cmd.shift = 1'b1;
                  d_we = 1'b1; d_wdata = NO_SLOT;
                  used_in = used_ff - 1'b1;
                  ptr_in = d_rdata;
                  state_in = ST_FIX;
               end else begin
                  cmd.idx = d_rdata; cmd.hit_sub = 1'b1;
                  delta_in = {{(WeightBits-CountBits){1'b0}}, cnt_ff};
               end
            end
         end
         ST_FIX: begin
            // rewrite dictionary entry of each bin that moved down
            if (ptr_ff >= used_ff) begin
               state_in = ST_TOT;
            end else begin
               d_we    = 1'b1;
               d_addr  = cv[ptr_ff[5:0]];
               d_wdata = ptr_ff;
               state_in = ST_FIXW;
            end
         end
         ST_FIXW: begin
            ptr_in   = ptr_ff + 1'b1;
            state_in = ST_FIX;
         end
         ST_TOT: begin
            if (dsub_ff) begin
               total_in = (total_ff == {TotalBits{1'b1}}) ? total_ff
                        : total_ff - {{(TotalBits-WeightBits){1'b0}}, delta_ff};
            end else begin
               tsum = {1'b0, total_ff} + {{(TotalBits+1-WeightBits){1'b0}}, delta_ff};
               ovf  = tsum[TotalBits];
               total_in = ovf ? {TotalBits{1'b1}} : tsum[TotalBits-1:0];
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: state_in = ST_IDLE;
         ST_EMIT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1; ritem_in = cv[0]; rw_in = cw[0];
               rempty_in = 1'b0; rerr_in = ERR_NONE;
               rlast_in = (ptr_ff == used_ff - 1'b1);
               cmd.rotate = 1'b1;
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff == used_ff - 1'b1) state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (!dv_busy && (!rv_ff || rsp_ready)) begin
               rv_in = 1'b1; ritem_in = cv[0];
               rw_in = (total_ff == '0) ? '0 : dv_quot;
               rempty_in = 1'b0; rerr_in = ERR_NONE;
               rlast_in = (ptr_ff == used_ff - 1'b1);
               cmd.rotate = 1'b1;
               ptr_in = ptr_ff + 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // finish rotating the chain back into insertion order
            if (ptr_ff[5:0] == '0 && ptr_ff != '0 || ptr_ff == SlotBits'(MaxBins)) begin
               if (op_ff == REQ_EMIT_NRM && ptr_ff < used_ff) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (op_ff == REQ_EMIT_NRM && ptr_ff < used_ff) begin
               dv_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.rotate = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         wipe_ff  <= '0;
         used_ff  <= '0;
         total_ff <= '0;
         rv_ff    <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wipe_ff  <= wipe_in;
         used_ff  <= used_in;
         total_ff <= total_in;
         rv_ff    <= rv_in;
         ptr_ff   <= ptr_in;
      end
      op_ff     <= op_in;
      smp_ff    <= smp_in;
      cnt_ff    <= cnt_in;
      slot_ff   <= slot_in;
      delta_ff  <= delta_in;
      dsub_ff   <= dsub_in;
      ritem_ff  <= ritem_in;
      rw_ff     <= rw_in;
      rempty_ff <= rempty_in;
      rerr_ff   <= rerr_in;
      rlast_ff  <= rlast_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_item       = ritem_ff;
   assign rsp_weight     = rw_ff;
   assign rsp_empty_res  = rempty_ff;
   assign rsp_error_code = rerr_ff;
   assign rsp_last       = rlast_ff;

`ifndef NO_ASSERTIONS
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SlotBits'(MaxBins))
      else $error("bin count above capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE && !rv_ff))
      else $error("input taken while busy");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rerr_ff != ERR_NONE) |-> rlast_ff)
      else $error("error beat without last");
`endif
endmodule
`default_nettype wire

[verif/sparse_histogram_accumulator_core_test.sv]
// self-checking testbench for sparse_histogram_accumulator_core: directed and random
// add/remove/emit/clear beats checked against a behavioral histogram; uses sha_pkg
`default_nettype none
module sparse_histogram_accumulator_core_test;
   import sha_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]            kind;
      logic [SampleBits-1:0] sample;
      logic [CountBits-1:0]  count;
   } hist_req_type;

   typedef struct packed {
      logic [SampleBits-1:0] item;
      logic [WeightBits-1:0] weight;
      logic                  empty_res;
      logic [1:0]            error_code;
      logic                  last;
   } hist_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = REQ_CLEAR;
   logic [SampleBits-1:0] req_sample = '0;
   logic [CountBits-1:0] req_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [SampleBits-1:0] rsp_item;
   logic [WeightBits-1:0] rsp_weight;
   logic rsp_empty_res;
   logic [1:0] rsp_error_code;
   logic rsp_last;

   sparse_histogram_accumulator_core dut (.*);

   always #5 clock = ~clock;

   hist_req_type pending_reqs[$];
   hist_rsp_type expected_rsps[$];
   int unsigned send_idle_pct = 22;
   int unsigned recv_idle_pct = 84;
   int errors = 0;
   longint cycles = 0;
   // set at the rising edge that took a request beat
   logic accepted_last = 1'b0;

   // histogram mirror
   logic [SlotBits-1:0]   slot_map[SampleValues];
   logic [SampleBits-1:0] bin_val[MaxBins];
   logic [WeightBits-1:0] bin_wt[MaxBins];
   int unsigned bins_used;
   logic [TotalBits-1:0] total_wt;

   function automatic hist_rsp_type mk_rsp(logic [7:0] it, logic [23:0] w, logic e,
                                           logic [1:0] ec, logic l);
      hist_rsp_type r;
      r.item = it; r.weight = w; r.empty_res = e; r.error_code = ec; r.last = l;
      return r;
   endfunction

   function automatic void clear_histogram();
      foreach (slot_map[i]) slot_map[i] = NO_SLOT;
      bins_used = 0;
      total_wt = '0;
   endfunction

   function automatic void sum_total();
      longint unsigned s;
      s = 0;
      for (int i = 0; i < bins_used; i++) s += bin_wt[i];
      total_wt = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void apply_histogram_req(hist_req_type q);
      int unsigned slot;
      longint unsigned w;
      slot = slot_map[q.sample];
      case (q.kind)
         REQ_ADD: begin
            if (slot < bins_used) begin
               w = bin_wt[slot] + q.count;
               bin_wt[slot] = (w > 24'hFFFFFF) ? 24'hFFFFFF : w[23:0];
            end else if (bins_used >= MaxBins) begin
               expected_rsps.push_back(mk_rsp(q.sample, '0, 1'b0, ERR_FULL, 1'b1));
               return;
            end else begin
               bin_val[bins_used] = q.sample;
               bin_wt[bins_used] = q.count;
               slot_map[q.sample] = bins_used[SlotBits-1:0];
               bins_used++;
            end
            sum_total();
         end
         REQ_REMOVE: begin
            if (slot >= bins_used) begin
               expected_rsps.push_back(mk_rsp(q.sample, '0, 1'b0, ERR_ABSENT, 1'b1));
               return;
            end
            if (bin_wt[slot] <= q.count) begin
               for (int i = slot; i + 1 < bins_used; i++) begin
                  bin_val[i] = bin_val[i+1];
                  bin_wt[i] = bin_wt[i+1];
                  slot_map[bin_val[i]] = i[SlotBits-1:0];
               end
               bins_used--;
               slot_map[q.sample] = NO_SLOT;
            end else begin
               bin_wt[slot] -= q.count;
            end
            sum_total();
         end
         REQ_EMIT_RAW, REQ_EMIT_NRM: begin
            if (bins_used == 0) begin
               expected_rsps.push_back(mk_rsp('0, '0, 1'b1, ERR_NONE, 1'b1));
               return;
            end
            for (int i = 0; i < bins_used; i++) begin
               w = bin_wt[i];
               if (q.kind == REQ_EMIT_NRM)
                  w = (total_wt == 0) ? 0 : (w * 65536 + total_wt / 2) / total_wt;
               expected_rsps.push_back(mk_rsp(bin_val[i], w[23:0], 1'b0, ERR_NONE,
                                              i + 1 == bins_used));
            end
         end
         REQ_CLEAR: clear_histogram();
         default: ;
      endcase
   endfunction

   function automatic hist_req_type mk_req(logic [2:0] k, logic [7:0] s, logic [15:0] c);
      hist_req_type q;
      q.kind = k; q.sample = s; q.count = c;
      return q;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (accepted_last) begin
            apply_histogram_req(mk_req(req_type, req_sample, req_count));
         end
         if (!req_valid || accepted_last) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               hist_req_type q;
               q = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_type <= q.kind;
               req_sample <= q.sample;
               req_count <= q.count;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      accepted_last <= !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         hist_rsp_type got, exp_r;
         got = mk_rsp(rsp_item, rsp_weight, rsp_empty_res, rsp_error_code, rsp_last);
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: actual %p", $time, got);
         end else begin
            exp_r = expected_rsps.pop_front();
            if (got !== exp_r) begin
               errors++;
               $display("%0t beat mismatch: expected %p actual %p", $time, exp_r, got);
            end
         end
      end
      if (cycles > 10000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      repeat (2) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic void push_random(int n);
      for (int i = 0; i < n; i++) begin
         int unsigned r;
         logic [7:0] s;
         logic [15:0] c;
         r = $urandom_range(99);
         // a narrow value range keeps removes and repeated adds hitting live bins
         s = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
         c = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(300));
         if (r < 45) pending_reqs.push_back(mk_req(REQ_ADD, s, c));
         else if (r < 80) pending_reqs.push_back(mk_req(REQ_REMOVE, s, c));
         else if (r < 88) pending_reqs.push_back(mk_req(REQ_EMIT_RAW, s, c));
         else if (r < 95) pending_reqs.push_back(mk_req(REQ_EMIT_NRM, s, c));
         else if (r < 97) pending_reqs.push_back(mk_req(REQ_CLEAR, s, c));
         else pending_reqs.push_back(mk_req(3'($urandom_range(7, 5)), s, c));
      end
   endfunction

   initial begin
      clear_histogram();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: empty emits, zero adds, saturation, absent remove, erase, bad codes
      pending_reqs.push_back(mk_req(REQ_EMIT_RAW, 8'h00, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_EMIT_NRM, 8'hFF, 16'hFFFF));
      pending_reqs.push_back(mk_req(REQ_ADD, 8'hFF, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_EMIT_NRM, 8'h00, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_REMOVE, 8'hFF, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_REMOVE, 8'hFF, 16'h0001));
      pending_reqs.push_back(mk_req(REQ_ADD, 8'h00, 16'hFFFF));
      pending_reqs.push_back(mk_req(REQ_ADD, 8'hAA, 16'h5555));
      pending_reqs.push_back(mk_req(REQ_ADD, 8'h55, 16'hAAAA));
      for (int i = 0; i < 256; i++) pending_reqs.push_back(mk_req(REQ_ADD, 8'h00, 16'hFFFF));
      pending_reqs.push_back(mk_req(REQ_EMIT_RAW, 8'h00, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_EMIT_NRM, 8'h00, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_REMOVE, 8'h00, 16'h1000));
      pending_reqs.push_back(mk_req(REQ_REMOVE, 8'hAA, 16'hFFFF));
      pending_reqs.push_back(mk_req(3'd5, 8'h11, 16'h1));
      pending_reqs.push_back(mk_req(3'd7, 8'h22, 16'h2));
      pending_reqs.push_back(mk_req(REQ_EMIT_RAW, 8'h00, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_CLEAR, 8'h00, 16'h0000));
      // fill the list, then overflow it, then erase from the front
      for (int i = 0; i < 65; i++) pending_reqs.push_back(mk_req(REQ_ADD, 8'(i * 3), 16'(i)));
      pending_reqs.push_back(mk_req(REQ_REMOVE, 8'h00, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_EMIT_NRM, 8'h00, 16'h0000));
      pending_reqs.push_back(mk_req(REQ_CLEAR, 8'h00, 16'h0000));
      push_random(10);
      wait_drained();
      send_idle_pct = 84;
      recv_idle_pct = 22;
      push_random(10);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random(9);
      wait_drained();
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
